/* rtl/mavt_pkg.sv */
package mavt_pkg;

  // Field and register widths
  localparam int SAMPLE_BITS   = 12;
  localparam int TIMER_BITS    = 24;
  localparam int TURN_BITS     = 24;
  localparam int ANGLE_BITS    = 43;
  localparam int VEL_BITS      = 48;
  localparam int CPR_BITS      = 12;
  localparam int TPU_BITS      = 8;
  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 12;

  // Fixed-point constants
  localparam logic [18:0] TWO_PI_Q16 = 19'd411775;
  localparam logic [34:0] TWO_PI_Q32 = 35'd26986075409;
  localparam logic [19:0] US_PER_S   = 20'd1000000;
  localparam logic [18:0] HALF_S_US  = 19'd500000;
  localparam int          FRAC_SHIFT = 16;

  // Derived datapath widths
  localparam int FRAC_PROD_BITS = SAMPLE_BITS + 35;
  localparam int QUO_RAW        = (VEL_BITS > FRAC_PROD_BITS) ? VEL_BITS : FRAC_PROD_BITS;
  localparam int QUO_BITS       = ((QUO_RAW + 1) / 2) * 2;
  localparam int DIV_BITS       = (TIMER_BITS > CPR_BITS) ? TIMER_BITS : CPR_BITS;
  localparam int DIV_STEPS      = QUO_BITS / 2;
  localparam int DIV_CNT_BITS   = $clog2(DIV_STEPS);
  localparam int FRAC_BITS      = QUO_BITS - FRAC_SHIFT + 1;
  localparam int TERM_BITS      = TURN_BITS + 20;
  localparam int ASUM_BITS      = TERM_BITS + 1;
  localparam int MAG_BITS       = ANGLE_BITS;
  localparam int MAG_LO_BITS    = (MAG_BITS + 1) / 2;
  localparam int MULT_BITS      = 20 + TPU_BITS;
  localparam int PP_BITS        = MAG_LO_BITS + MULT_BITS;
  localparam int PROD_BITS      = MAG_BITS + MULT_BITS;
  localparam int LIM_BITS       = 19 + TPU_BITS;
  localparam int CMP_BITS       = (LIM_BITS > TIMER_BITS) ? LIM_BITS : TIMER_BITS;
  localparam int WRAP_BITS      = ((SAMPLE_BITS > CPR_BITS) ? SAMPLE_BITS : CPR_BITS) + 3;

  typedef logic        [SAMPLE_BITS-1:0]    sample_t;
  typedef logic        [TIMER_BITS-1:0]     timer_t;
  typedef logic signed [TURN_BITS-1:0]      turn_t;
  typedef logic signed [ANGLE_BITS-1:0]     angle_t;
  typedef logic signed [ANGLE_BITS:0]       dang_t;
  typedef logic signed [VEL_BITS-1:0]       vel_t;
  typedef logic        [CPR_BITS-1:0]       cpr_t;
  typedef logic        [TPU_BITS-1:0]       tpu_t;
  typedef logic        [CFG_IDX_BITS-1:0]   cfg_idx_t;
  typedef logic        [CFG_DATA_BITS-1:0]  cfg_data_t;
  typedef logic        [FRAC_PROD_BITS-1:0] fprod_t;
  typedef logic        [QUO_BITS-1:0]       quo_t;
  typedef logic        [DIV_BITS-1:0]       div_t;
  typedef logic        [DIV_BITS:0]         rem_ext_t;
  typedef logic        [DIV_CNT_BITS-1:0]   cnt_t;
  typedef logic        [FRAC_BITS-1:0]      frac_t;
  typedef logic signed [TERM_BITS-1:0]      term_t;
  typedef logic signed [ASUM_BITS-1:0]      asum_t;
  typedef logic        [MAG_BITS-1:0]       mag_t;
  typedef logic        [MAG_LO_BITS-1:0]    maglo_t;
  typedef logic        [MULT_BITS-1:0]      mult_t;
  typedef logic        [PP_BITS-1:0]        pp_t;
  typedef logic        [PROD_BITS-1:0]      prod_t;
  typedef logic        [LIM_BITS-1:0]       lim_t;
  typedef logic        [CMP_BITS-1:0]       cmp_t;
  typedef logic        [WRAP_BITS-1:0]      wrap_t;

  localparam cpr_t   CPR_RESET  = cpr_t'(1023);
  localparam tpu_t   TPU_RESET  = tpu_t'(9);
  localparam timer_t TIMER_MAX  = '1;
  localparam turn_t  TURN_MAX   = {1'b0, {(TURN_BITS-1){1'b1}}};
  localparam turn_t  TURN_MIN   = {1'b1, {(TURN_BITS-1){1'b0}}};
  localparam angle_t ANGLE_MAX  = {1'b0, {(ANGLE_BITS-1){1'b1}}};
  localparam angle_t ANGLE_MIN  = {1'b1, {(ANGLE_BITS-1){1'b0}}};
  localparam vel_t   VEL_MAX    = {1'b0, {(VEL_BITS-1){1'b1}}};
  localparam mult_t  MS_MULT    = mult_t'(1000);
  localparam quo_t   ROUND_HALF = quo_t'(32768);

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_CPR = 1'b0,
    REG_TPU = 1'b1
  } cfg_reg_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ASTART,
    ST_ADIV,
    ST_ANGLE,
    ST_VPREP,
    ST_VMLO,
    ST_VMHI,
    ST_VCHK,
    ST_VDIV,
    ST_VFIN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic    op;
    sample_t sample;
    timer_t  timestamp;
  } item_t;

  typedef struct packed {
    angle_t angle;
    vel_t   velocity;
    logic   velocity_valid;
  } res_t;

  typedef struct packed {
    cpr_t cpr;
    tpu_t tpu;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load_in;
    logic prep;
    logic angle_start;
    logic angle_set;
    logic vel_prep;
    logic mul_lo;
    logic mul_hi;
    logic vel_start;
    logic vel_fin;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic div_done;
    logic op;
    logic prime_item;
    logic ovf;
  } status_t;

endpackage

/* rtl/mavt_if.sv */
interface mavt_in_if;
  logic                 valid;
  logic                 ready;
  logic                 op;
  mavt_pkg::sample_t    sample;
  mavt_pkg::timer_t     timestamp;

  modport source (output valid, op, sample, timestamp, input ready);
  modport sink   (input valid, op, sample, timestamp, output ready);
endinterface

interface mavt_out_if;
  logic                 valid;
  logic                 ready;
  mavt_pkg::angle_t     angle;
  mavt_pkg::vel_t       velocity;
  logic                 velocity_valid;

  modport source (output valid, angle, velocity, velocity_valid, input ready);
  modport sink   (input valid, angle, velocity, velocity_valid, output ready);
endinterface

interface mavt_cfg_if;
  logic                 valid;
  logic                 ready;
  mavt_pkg::cfg_idx_t   index;
  mavt_pkg::cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/multiturn_angle_velocity_tracker.sv */
// Channel  Dir  Payload                              Handshake
// in_ch    in   op, sample, timestamp                valid/ready
// out_ch   out  angle, velocity, velocity_valid      valid/ready
// cfg_ch   in   index (0 counts_per_rev, 1 ticks_per_us), data   valid/ready (ready tied high)
//
// Angle-only and priming items take one divide, for the angle; a velocity item adds a second
// divide, which is skipped when the product is already past the saturation limit. Both run
// on the shared divider, 2 quotient bits/cycle. A new item is accepted only after the result
// of the last one has been pushed to the output register.
// Reset is synchronous, active low; it clears the tracker state and restores the register
// defaults. A result waits in the output register; the sequencer stalls while it is full.
module multiturn_angle_velocity_tracker (
  input  logic        clk,
  input  logic        rst_n,
  mavt_in_if.sink     in_ch,
  mavt_out_if.source  out_ch,
  mavt_cfg_if.sink    cfg_ch
);

  mavt_pkg::cfg_t    cfg_r;
  logic              out_valid_r;
  mavt_pkg::res_t    out_res_r;

  mavt_pkg::item_t   item;
  mavt_pkg::cmd_t    cmd;
  mavt_pkg::status_t status;
  mavt_pkg::res_t    res;
  logic              in_ready;
  logic              push;
  logic              out_free;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cpr <= mavt_pkg::CPR_RESET;
      cfg_r.tpu <= mavt_pkg::TPU_RESET;
    end else if (cfg_ch.valid) begin
      case (mavt_pkg::cfg_reg_t'(cfg_ch.index))
        mavt_pkg::REG_CPR: cfg_r.cpr <= cfg_ch.data[mavt_pkg::CPR_BITS-1:0];
        mavt_pkg::REG_TPU: cfg_r.tpu <= cfg_ch.data[mavt_pkg::TPU_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign item.op        = in_ch.op;
  assign item.sample    = in_ch.sample;
  assign item.timestamp = in_ch.timestamp;
  assign in_ch.ready    = in_ready;

  assign out_free = !out_valid_r || out_ch.ready;

  mavt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_ready),
    .push     (push),
    .cmd      (cmd)
  );

  mavt_dp u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (cmd),
    .cfg    (cfg_r),
    .item   (item),
    .status (status),
    .res    (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.angle          = out_res_r.angle;
  assign out_ch.velocity       = out_res_r.velocity;
  assign out_ch.velocity_valid = out_res_r.velocity_valid;

  // A result only lands in a free output register
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free)
    else $error("result pushed into occupied output register");

  // One item at a time: no accept right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while item in flight");

  // No velocity value without its valid flag
  a_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_res_r.velocity_valid) |-> (out_res_r.velocity == '0))
    else $error("velocity nonzero without velocity_valid");

  // Pushed result is visible next cycle
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> out_valid_r)
    else $error("pushed result not presented");

endmodule

/* rtl/mavt_div.sv */
// Restoring divider, two quotient bits per cycle.
// Requires hi < divisor; quotient = ({hi, lo}) / divisor.
module mavt_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  mavt_pkg::div_t divisor,
  input  mavt_pkg::div_t hi,
  input  mavt_pkg::quo_t lo,
  output mavt_pkg::quo_t quotient,
  output logic           done
);

  mavt_pkg::div_t     rem_r;
  mavt_pkg::div_t     dvs_r;
  mavt_pkg::quo_t     quo_r;
  mavt_pkg::cnt_t     cnt_r;
  logic               busy_r;
  logic               done_r;

  mavt_pkg::rem_ext_t dvs_ext;
  mavt_pkg::rem_ext_t t1;
  mavt_pkg::rem_ext_t r1;
  mavt_pkg::rem_ext_t t2;
  mavt_pkg::rem_ext_t r2;
  logic               ge1;
  logic               ge2;

  // Two shift-compare-subtract steps
  always_comb begin
    dvs_ext = {1'b0, dvs_r};
    t1      = {rem_r, quo_r[mavt_pkg::QUO_BITS-1]};
    ge1     = (t1 >= dvs_ext);
    r1      = ge1 ? (t1 - dvs_ext) : t1;
    t2      = {r1[mavt_pkg::DIV_BITS-1:0], quo_r[mavt_pkg::QUO_BITS-2]};
    ge2     = (t2 >= dvs_ext);
    r2      = ge2 ? (t2 - dvs_ext) : t2;
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= mavt_pkg::cnt_t'(mavt_pkg::DIV_STEPS - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // Operands: dividend bits shift out, quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= hi;
      dvs_r <= divisor;
      quo_r <= lo;
    end else if (busy_r) begin
      rem_r <= r2[mavt_pkg::DIV_BITS-1:0];
      quo_r <= {quo_r[mavt_pkg::QUO_BITS-3:0], ge1, ge2};
    end
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

/* rtl/mavt_dp.sv */
// Datapath: unwrap state, angle scaling, velocity product and quotient.
module mavt_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  mavt_pkg::cmd_t    cmd,
  input  mavt_pkg::cfg_t    cfg,
  input  mavt_pkg::item_t   item,
  output mavt_pkg::status_t status,
  output mavt_pkg::res_t    res
);

  // Latched item
  logic              op_r;
  mavt_pkg::sample_t sample_r;
  mavt_pkg::timer_t  ts_r;

  // Tracker state
  logic              primed_r;
  logic              prime_item_r;
  mavt_pkg::sample_t last_sample_r;
  mavt_pkg::turn_t   turn_r;
  mavt_pkg::angle_t  prev_vel_angle_r;
  mavt_pkg::timer_t  prev_ts_r;

  // Work registers
  mavt_pkg::fprod_t  frac_prod_r;
  mavt_pkg::timer_t  ticks_r;
  mavt_pkg::lim_t    lim_r;
  mavt_pkg::mult_t   mult_r;
  mavt_pkg::term_t   turn_term_r;
  mavt_pkg::angle_t  angle_r;
  mavt_pkg::mag_t    mag_r;
  logic              neg_r;
  logic              use_ms_r;
  mavt_pkg::prod_t   prod_r;
  mavt_pkg::vel_t    vel_r;
  logic              vvalid_r;

  // Combinational
  mavt_pkg::cpr_t    cpr_eff;
  mavt_pkg::tpu_t    tpu_eff;
  logic signed [mavt_pkg::SAMPLE_BITS:0] d;
  logic signed [mavt_pkg::SAMPLE_BITS:0] nd;
  mavt_pkg::sample_t ad;
  logic              wrap;
  mavt_pkg::turn_t   turn_nxt;
  mavt_pkg::timer_t  ticks_calc;
  mavt_pkg::frac_t   frac;
  mavt_pkg::asum_t   asum;
  mavt_pkg::angle_t  angle_nxt;
  mavt_pkg::dang_t   da;
  mavt_pkg::dang_t   nda;
  mavt_pkg::mult_t   msel;
  mavt_pkg::div_t    dsel;
  mavt_pkg::maglo_t  mul_a;
  mavt_pkg::pp_t     pp;
  logic              ovf;
  logic              vsat;
  mavt_pkg::vel_t    vmag;

  // Divider port
  logic              div_start;
  mavt_pkg::div_t    div_dvs;
  mavt_pkg::div_t    div_hi;
  mavt_pkg::quo_t    div_lo;
  mavt_pkg::quo_t    quo;
  logic              div_done;

  // Zero registers act as one
  assign cpr_eff = (cfg.cpr == '0) ? mavt_pkg::cpr_t'(1) : cfg.cpr;
  assign tpu_eff = (cfg.tpu == '0) ? mavt_pkg::tpu_t'(1) : cfg.tpu;

  // Wrap detection and saturating turn count
  always_comb begin
    d    = $signed({1'b0, sample_r}) - $signed({1'b0, last_sample_r});
    nd   = -d;
    ad   = d[mavt_pkg::SAMPLE_BITS] ? nd[mavt_pkg::SAMPLE_BITS-1:0]
                                    : d[mavt_pkg::SAMPLE_BITS-1:0];
    wrap = (mavt_pkg::wrap_t'(ad) * mavt_pkg::wrap_t'(5)) >
           (mavt_pkg::wrap_t'(cpr_eff) << 2);
    turn_nxt = turn_r;
    if (wrap) begin
      if (!d[mavt_pkg::SAMPLE_BITS]) begin
        if (turn_r != mavt_pkg::TURN_MIN) turn_nxt = turn_r - 1'b1;
      end else begin
        if (turn_r != mavt_pkg::TURN_MAX) turn_nxt = turn_r + 1'b1;
      end
    end
  end

  // Elapsed ticks on the down-counter
  always_comb begin
    if (ts_r < prev_ts_r) begin
      ticks_calc = prev_ts_r - ts_r;
    end else begin
      ticks_calc = mavt_pkg::TIMER_MAX - ts_r + prev_ts_r;
    end
  end

  // Angle: round the scaled fraction, add whole turns, saturate
  always_comb begin
    frac = mavt_pkg::frac_t'((quo + mavt_pkg::ROUND_HALF) >> mavt_pkg::FRAC_SHIFT);
    asum = mavt_pkg::asum_t'(turn_term_r) + mavt_pkg::asum_t'(frac);
    if (asum > mavt_pkg::asum_t'(mavt_pkg::ANGLE_MAX)) begin
      angle_nxt = mavt_pkg::ANGLE_MAX;
    end else if (asum < mavt_pkg::asum_t'(mavt_pkg::ANGLE_MIN)) begin
      angle_nxt = mavt_pkg::ANGLE_MIN;
    end else begin
      angle_nxt = mavt_pkg::angle_t'(asum);
    end
  end

  // Velocity operands
  always_comb begin
    da    = mavt_pkg::dang_t'(angle_r) - mavt_pkg::dang_t'(prev_vel_angle_r);
    nda   = -da;
    msel  = use_ms_r ? mavt_pkg::MS_MULT : mult_r;
    dsel  = use_ms_r ? mavt_pkg::div_t'(1) : mavt_pkg::div_t'(ticks_r);
    mul_a = cmd.mul_hi ? mavt_pkg::maglo_t'(mag_r[mavt_pkg::MAG_BITS-1:mavt_pkg::MAG_LO_BITS])
                       : mag_r[mavt_pkg::MAG_LO_BITS-1:0];
    pp    = mavt_pkg::pp_t'(mul_a) * mavt_pkg::pp_t'(msel);
    // quotient would reach 2^QUO_BITS
    ovf   = mavt_pkg::div_t'(prod_r[mavt_pkg::PROD_BITS-1:mavt_pkg::QUO_BITS]) >= dsel;
    vsat  = ovf || (|quo[mavt_pkg::QUO_BITS-1:mavt_pkg::VEL_BITS-1]);
    vmag  = vsat ? mavt_pkg::VEL_MAX
                 : mavt_pkg::vel_t'(quo[mavt_pkg::VEL_BITS-2:0]);
  end

  // Shared divider operands
  always_comb begin
    div_start = cmd.angle_start || cmd.vel_start;
    if (cmd.vel_start) begin
      div_dvs = dsel;
      div_hi  = mavt_pkg::div_t'(prod_r[mavt_pkg::PROD_BITS-1:mavt_pkg::QUO_BITS]);
      div_lo  = prod_r[mavt_pkg::QUO_BITS-1:0];
    end else begin
      div_dvs = mavt_pkg::div_t'(cpr_eff);
      div_hi  = '0;
      div_lo  = mavt_pkg::quo_t'(frac_prod_r);
    end
  end

  mavt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .divisor  (div_dvs),
    .hi       (div_hi),
    .lo       (div_lo),
    .quotient (quo),
    .done     (div_done)
  );

  // Tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      primed_r         <= 1'b0;
      last_sample_r    <= '0;
      turn_r           <= '0;
      prev_vel_angle_r <= '0;
      prev_ts_r        <= '0;
    end else begin
      if (cmd.prep) begin
        primed_r      <= 1'b1;
        last_sample_r <= sample_r;
        turn_r        <= primed_r ? turn_nxt : '0;
      end
      if (cmd.angle_set && prime_item_r) begin
        prev_vel_angle_r <= angle_nxt;
      end
      if (cmd.vel_fin) begin
        prev_vel_angle_r <= angle_r;
        prev_ts_r        <= ts_r;
      end
    end
  end

  // Item and work registers
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= item.op;
      sample_r <= item.sample;
      ts_r     <= item.timestamp;
      vel_r    <= '0;
      vvalid_r <= 1'b0;
    end
    if (cmd.prep) begin
      prime_item_r <= !primed_r;
      frac_prod_r  <= mavt_pkg::fprod_t'(sample_r) * mavt_pkg::fprod_t'(mavt_pkg::TWO_PI_Q32);
      ticks_r      <= ticks_calc;
      lim_r        <= mavt_pkg::lim_t'(tpu_eff) * mavt_pkg::lim_t'(mavt_pkg::HALF_S_US);
      mult_r       <= mavt_pkg::mult_t'(tpu_eff) * mavt_pkg::mult_t'(mavt_pkg::US_PER_S);
    end
    if (cmd.angle_start) begin
      turn_term_r <= mavt_pkg::term_t'(turn_r) *
                     mavt_pkg::term_t'($signed({1'b0, mavt_pkg::TWO_PI_Q16}));
    end
    if (cmd.angle_set) begin
      angle_r <= angle_nxt;
    end
    if (cmd.vel_prep) begin
      neg_r    <= da[mavt_pkg::ANGLE_BITS];
      mag_r    <= da[mavt_pkg::ANGLE_BITS] ? nda[mavt_pkg::MAG_BITS-1:0]
                                           : da[mavt_pkg::MAG_BITS-1:0];
      use_ms_r <= (ticks_r == '0) ||
                  (mavt_pkg::cmp_t'(ticks_r) > mavt_pkg::cmp_t'(lim_r));
    end
    if (cmd.mul_lo) begin
      prod_r <= mavt_pkg::prod_t'(pp);
    end
    if (cmd.mul_hi) begin
      prod_r <= prod_r + (mavt_pkg::prod_t'(pp) << mavt_pkg::MAG_LO_BITS);
    end
    if (cmd.vel_fin) begin
      vel_r    <= neg_r ? -vmag : vmag;
      vvalid_r <= 1'b1;
    end
  end

  assign status.div_done   = div_done;
  assign status.op         = op_r;
  assign status.prime_item = prime_item_r;
  assign status.ovf        = ovf;

  assign res.angle          = angle_r;
  assign res.velocity       = vel_r;
  assign res.velocity_valid = vvalid_r;

endmodule

/* rtl/mavt_ctrl.sv */
// Item sequencer: steps the datapath through angle and velocity phases.
module mavt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_free,
  input  mavt_pkg::status_t status,
  output logic              in_ready,
  output logic              push,
  output mavt_pkg::cmd_t    cmd
);

  mavt_pkg::state_t state_r;
  mavt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mavt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mavt_pkg::ST_IDLE:   if (in_valid) state_nxt = mavt_pkg::ST_PREP;
      mavt_pkg::ST_PREP:   state_nxt = mavt_pkg::ST_ASTART;
      mavt_pkg::ST_ASTART: state_nxt = mavt_pkg::ST_ADIV;
      mavt_pkg::ST_ADIV:   if (status.div_done) state_nxt = mavt_pkg::ST_ANGLE;
      mavt_pkg::ST_ANGLE: begin
        if (status.prime_item || !status.op) begin
          state_nxt = mavt_pkg::ST_FIN;
        end else begin
          state_nxt = mavt_pkg::ST_VPREP;
        end
      end
      mavt_pkg::ST_VPREP:  state_nxt = mavt_pkg::ST_VMLO;
      mavt_pkg::ST_VMLO:   state_nxt = mavt_pkg::ST_VMHI;
      mavt_pkg::ST_VMHI:   state_nxt = mavt_pkg::ST_VCHK;
      mavt_pkg::ST_VCHK: begin
        // quotient already past the limit: skip the divide
        if (status.ovf) begin
          state_nxt = mavt_pkg::ST_VFIN;
        end else begin
          state_nxt = mavt_pkg::ST_VDIV;
        end
      end
      mavt_pkg::ST_VDIV:   if (status.div_done) state_nxt = mavt_pkg::ST_VFIN;
      mavt_pkg::ST_VFIN:   state_nxt = mavt_pkg::ST_FIN;
      mavt_pkg::ST_FIN:    if (out_free) state_nxt = mavt_pkg::ST_IDLE;
      default:             state_nxt = mavt_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    push     = 1'b0;
    case (state_r)
      mavt_pkg::ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.load_in = in_valid;
      end
      mavt_pkg::ST_PREP:   cmd.prep        = 1'b1;
      mavt_pkg::ST_ASTART: cmd.angle_start = 1'b1;
      mavt_pkg::ST_ANGLE:  cmd.angle_set   = 1'b1;
      mavt_pkg::ST_VPREP:  cmd.vel_prep    = 1'b1;
      mavt_pkg::ST_VMLO:   cmd.mul_lo      = 1'b1;
      mavt_pkg::ST_VMHI:   cmd.mul_hi      = 1'b1;
      mavt_pkg::ST_VCHK:   cmd.vel_start   = !status.ovf;
      mavt_pkg::ST_VFIN:   cmd.vel_fin     = 1'b1;
      mavt_pkg::ST_FIN:    push            = out_free;
      default: begin
      end
    endcase
  end

endmodule

/* tb/sv/tb_multiturn_angle_velocity_tracker.sv */
`timescale 1ns / 100ps

module tb_multiturn_angle_velocity_tracker;
  import mavt_pkg::*;

  typedef longint unsigned u64_t;

  // Row kinds of the directed plan
  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_CHOKE,
    RX_TOGGLE
  } rx_mode_t;

  typedef struct {
    row_kind_t kind;
    cfg_reg_t  sel;
    logic      op;
    cfg_data_t val;
    timer_t    ts;
    bit        typed;
    angle_t    w_angle;
    vel_t      w_vel;
    logic      w_vv;
  } plan_row_t;

  localparam int PLAN_ROWS     = 30;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS   = 175;
  localparam int CYCLE_LIMIT   = 1000000;

  // Directed plan; rows with typed set carry their result, others use the predictor
  plan_row_t plan [0:PLAN_ROWS-1] = '{
    // priming item, op ignored
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd0, 24'd0, 1'b1, 43'sd0, 48'sd0, 1'b1 ^ 1'b1},
    // zero elapsed ticks falls back to 1 ms
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd0, 24'hFFFFFF, 1'b1, 43'sd0, 48'sd0, 1'b1},
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd4095, 24'd0, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd1000, 24'hFFFFF0, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd1010, 24'hFFFF00, 1'b0, 43'sd0, 48'sd0, 1'b0},
    // exactly half a second, then just over it
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd0, 24'd12276960, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd5, 24'd7776959, 1'b0, 43'sd0, 48'sd0, 1'b0},
    // timer moved up: wraps to a huge count
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd3, 24'd7776960, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_CFG, REG_TPU, 1'b0, 12'd255, 24'd0, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_CFG, REG_CPR, 1'b0, 12'd4095, 24'd0, 1'b0, 43'sd0, 48'sd0, 1'b0},
    // two turns down, then one tick: velocity saturates
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd4095, 24'd7776960, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd2000, 24'd7776960, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd0, 24'd7776960, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd4095, 24'd7776960, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd2000, 24'd7776960, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd0, 24'd7776960, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd4095, 24'd7776960, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd4095, 24'd7776959, 1'b0, 43'sd0, 48'sd0, 1'b0},
    // same timestamp again
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd4095, 24'd7776959, 1'b0, 43'sd0, 48'sd0, 1'b0},
    // zero registers act as one
    '{ROW_CFG, REG_CPR, 1'b0, 12'd0, 24'd0, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_CFG, REG_TPU, 1'b0, 12'd0, 24'd0, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd1, 24'd7776959, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd4095, 24'd7776859, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd2048, 24'd7276859, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_CFG, REG_CPR, 1'b0, 12'd1, 24'd0, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_CFG, REG_TPU, 1'b0, 12'd1, 24'd0, 1'b0, 43'sd0, 48'sd0, 1'b0},
    // one count of motion is a wrap at one count per rev
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd0, 24'd7276859, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b0, 12'd1, 24'd7276859, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd1, 24'd7276858, 1'b0, 43'sd0, 48'sd0, 1'b0},
    '{ROW_ITEM, REG_CPR, 1'b1, 12'd4095, 24'd0, 1'b0, 43'sd0, 48'sd0, 1'b0}
  };

  logic clk = 1'b0;
  logic rst_n;

  mavt_in_if  in_ch ();
  mavt_out_if out_ch ();
  mavt_cfg_if cfg_ch ();

  multiturn_angle_velocity_tracker dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor copy of tracker state and registers
  bit     trk_primed    = 1'b0;
  sample_t trk_last     = '0;
  turn_t  trk_turns     = '0;
  angle_t trk_vel_angle = '0;
  timer_t trk_vel_ts    = '0;
  cpr_t   trk_cpr       = CPR_RESET;
  tpu_t   trk_tpu       = TPU_RESET;

  res_t   pending_results [$];
  int     mismatch_count = 0;
  int     cycle_count    = 0;
  int     burst_left     = 0;
  int     track_pos      = 0;
  timer_t timer_now      = '0;

  rx_mode_t rx_mode = RX_OPEN;
  int       rx_left = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Expected result of one item; advances the predictor state
  function automatic res_t track_item(input logic op, input sample_t s, input timer_t now);
    res_t    r;
    bit      first;
    u64_t    cpr, tpu, frac, ticks, mult, dv, mag, qa, ra, mv;
    longint  a, da, jump, jump_abs;
    cpr = (trk_cpr == '0) ? 64'd1 : u64_t'(trk_cpr);
    tpu = (trk_tpu == '0) ? 64'd1 : u64_t'(trk_tpu);
    r = '0;
    first = !trk_primed;
    if (first) begin
      trk_primed = 1'b1;
      trk_turns  = '0;
    end else begin
      // jump over 0.8 rev is a wrap; count moves against the jump
      jump     = longint'(s) - longint'(trk_last);
      jump_abs = (jump < 0) ? -jump : jump;
      if (5 * jump_abs > 4 * longint'(cpr)) begin
        if (jump > 0) begin
          if (trk_turns != TURN_MIN) trk_turns = trk_turns - turn_t'(1);
        end else if (trk_turns != TURN_MAX) begin
          trk_turns = trk_turns + turn_t'(1);
        end
      end
    end
    trk_last = s;
    frac = ((u64_t'(s) * u64_t'(TWO_PI_Q32)) / cpr + 64'd32768) >> FRAC_SHIFT;
    a = longint'(trk_turns) * longint'(TWO_PI_Q16) + longint'(frac);
    if (a > longint'(ANGLE_MAX)) a = longint'(ANGLE_MAX);
    if (a < longint'(ANGLE_MIN)) a = longint'(ANGLE_MIN);
    r.angle = angle_t'(a);
    if (first) begin
      trk_vel_angle = r.angle;
    end else if (op) begin
      da = a - longint'(trk_vel_angle);
      // down-counter elapsed ticks
      if (now < trk_vel_ts) ticks = u64_t'(trk_vel_ts - now);
      else ticks = u64_t'(TIMER_MAX) - u64_t'(now) + u64_t'(trk_vel_ts);
      // no elapsed time or over half a second: take 1 ms
      if (ticks == 64'd0 || ticks > 64'd500000 * tpu) begin
        mult = 64'd1000;
        dv   = 64'd1;
      end else begin
        mult = 64'd1000000 * tpu;
        dv   = ticks;
      end
      mag = u64_t'((da < 0) ? -da : da);
      qa  = mag / dv;
      ra  = mag % dv;
      if (qa > u64_t'(VEL_MAX) / mult) begin
        mv = u64_t'(VEL_MAX);
      end else begin
        mv = qa * mult + (ra * mult) / dv;
        if (mv > u64_t'(VEL_MAX)) mv = u64_t'(VEL_MAX);
      end
      if (da < 0) r.velocity = -vel_t'(mv);
      else r.velocity = vel_t'(mv);
      r.velocity_valid = 1'b1;
      trk_vel_angle = r.angle;
      trk_vel_ts    = now;
    end
    return r;
  endfunction

  // Offer one item; called and returns at a falling edge
  task automatic push_item(input logic op, input sample_t s, input timer_t ts,
                           input bit typed, input res_t want);
    res_t pred;
    in_ch.valid     = 1'b1;
    in_ch.op        = op;
    in_ch.sample    = s;
    in_ch.timestamp = ts;
    do @(posedge clk); while (!in_ch.ready);
    pred = track_item(op, s, ts);
    pending_results.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  // Register write; only issued while the block is idle
  task automatic write_reg(input cfg_reg_t sel, input cfg_data_t d);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = sel;
    cfg_ch.data  = d;
    do @(posedge clk); while (!cfg_ch.ready);
    if (sel == REG_CPR) trk_cpr = cpr_t'(d);
    else trk_tpu = tpu_t'(d);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // Hold off the sender until every pending result is out
  task automatic drain(input int tail);
    in_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (tail) @(negedge clk);
  endtask

  // Sender bursts with random gaps
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 12));
      if (gap > 0) begin
        in_ch.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
  endtask

  // Mostly smooth motion with wraps, plus noise samples and odd time steps
  task automatic run_random_phase(input int n);
    int          c, span, pick, step;
    int unsigned lim, dt;
    sample_t     s;
    logic        op;
    for (int k = 0; k < n; k++) begin
      c    = (trk_cpr == '0) ? 1 : int'(trk_cpr);
      lim  = 500000 * ((trk_tpu == '0) ? 1 : int'(trk_tpu));
      span = (c >= 16) ? c / 8 : 1;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        step      = int'($urandom_range(0, 2 * span)) - span;
        track_pos = (track_pos + step) % c;
        if (track_pos < 0) track_pos += c;
        s = sample_t'(track_pos);
      end else if (pick < 82) begin
        track_pos = $urandom_range(0, c - 1);
        s = sample_t'(track_pos);
      end else begin
        s = sample_t'($urandom_range(0, 4095));
        track_pos = int'(s) % c;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) dt = $urandom_range(1, 3000);
      else if (pick < 75) dt = $urandom_range(1, lim);
      else if (pick < 85) dt = lim + $urandom_range(0, 2) - 1;
      else if (pick < 92) dt = 0;
      else dt = $urandom;
      timer_now = timer_t'(timer_now - dt);
      op = ($urandom_range(0, 9) < 7);
      pace();
      if ($urandom_range(0, 199) == 0) drain(0);
      push_item(op, s, timer_now, 1'b0, '0);
    end
  endtask

  // Receiver stall pattern
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:  out_ch.ready = 1'b1;
      RX_COIN:  out_ch.ready = 1'($urandom_range(0, 1));
      RX_CHOKE: out_ch.ready = ($urandom_range(0, 7) == 0);
      default:  out_ch.ready = ~out_ch.ready;
    endcase
  end

  // Result checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: angle %0d", out_ch.angle);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.angle !== want.angle) begin
          $error("angle: expected %0d, got %0d", want.angle, out_ch.angle);
          mismatch_count++;
        end
        if (out_ch.velocity !== want.velocity) begin
          $error("velocity: expected %0d, got %0d", want.velocity, out_ch.velocity);
          mismatch_count++;
        end
        if (out_ch.velocity_valid !== want.velocity_valid) begin
          $error("velocity_valid: expected %0d, got %0d", want.velocity_valid,
                 out_ch.velocity_valid);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.op        = 1'b0;
    in_ch.sample    = '0;
    in_ch.timestamp = '0;
    out_ch.ready    = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_CPR;
    cfg_ch.data     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed plan
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        drain(4);
        write_reg(plan[i].sel, plan[i].val);
      end else begin
        pace();
        push_item(plan[i].op, sample_t'(plan[i].val), plan[i].ts, plan[i].typed,
                  '{angle: plan[i].w_angle, velocity: plan[i].w_vel,
                    velocity_valid: plan[i].w_vv});
      end
    end

    // random phases, each under its own register setting
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain(4);
      case (p)
        0: begin
          write_reg(REG_CPR, cfg_data_t'(1023));
          write_reg(REG_TPU, cfg_data_t'(9));
        end
        1: begin
          write_reg(REG_CPR, cfg_data_t'(4095));
          write_reg(REG_TPU, cfg_data_t'(255));
        end
        2: begin
          write_reg(REG_CPR, cfg_data_t'(1));
          write_reg(REG_TPU, cfg_data_t'(1));
        end
        3: begin
          write_reg(REG_CPR, cfg_data_t'(4095));
          write_reg(REG_TPU, cfg_data_t'(1));
        end
        4: begin
          write_reg(REG_CPR, cfg_data_t'(1));
          write_reg(REG_TPU, cfg_data_t'(255));
        end
        default: begin
          write_reg(REG_CPR, cfg_data_t'($urandom_range(0, 4095)));
          write_reg(REG_TPU, cfg_data_t'($urandom_range(0, 4095)));
        end
      endcase
      run_random_phase(PHASE_ITEMS);
    end

    drain(100);
    if (pending_results.size() != 0) begin
      $error("%0d result items never arrived", pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
